[rtl/sbdp_pkg.sv]
// shared types and constants for the single-bin dtft power unit
package sbdp_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROT_COS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_SIN = 2'd1;

    // result widths
    localparam int BIN_W = 32;
    localparam int PWR_W = 64;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_UPDATE,
        ST_ROUND,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_PWR,
        ST_PUSH
    } t_state;

    // product selection for the two shared multipliers
    typedef enum logic [2:0] {
        MUL_P0,
        MUL_P1,
        MUL_P2,
        MUL_P3,
        MUL_SQ_RE,
        MUL_SQ_IM
    } t_mul_op;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    mul_en;
        t_mul_op mul_op;
        logic    acc_en;
        t_mul_op acc_op;
        logic    upd_en;
        logic    round_en;
        logic    push;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;
        logic out_free;
    } t_sts;

endpackage

[rtl/sbdp_if.sv]
// valid/ready channel interfaces: samples in, bin results out, register writes

interface sbdp_smp_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;
    logic                          is_last;

    modport source (output valid, output sample_re, output sample_im, output is_last,
                    input ready);
    modport sink   (input valid, input sample_re, input sample_im, input is_last,
                    output ready);
endinterface

interface sbdp_bin_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sbdp_pkg::BIN_W-1:0]    bin_re;
    logic signed [sbdp_pkg::BIN_W-1:0]    bin_im;
    logic        [sbdp_pkg::PWR_W-1:0]    bin_power;

    modport source (output valid, output bin_re, output bin_im, output bin_power,
                    input ready);
    modport sink   (input valid, input bin_re, input bin_im, input bin_power,
                    output ready);
endinterface

interface sbdp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [sbdp_pkg::CFG_IDX_W-1:0]      index;
    logic [sbdp_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/sbdp_ctrl.sv]
// sequencer for the shared multipliers, accumulate, update and result steps
module sbdp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_fire,
    input  sbdp_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output sbdp_pkg::t_cmd  o_cmd
);
    import sbdp_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_step,  n_step;

    // map a product step to its operand selection
    function automatic t_mul_op step_op(input logic [1:0] k);
        t_mul_op op;
        unique case (k)
            2'd0: op = MUL_P0;
            2'd1: op = MUL_P1;
            2'd2: op = MUL_P2;
            2'd3: op = MUL_P3;
        endcase
        return op;
    endfunction

    // state and step registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (i_in_fire) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:  n_state = ST_UPDATE;
            ST_UPDATE: n_state = i_sts.last ? ST_ROUND : ST_IDLE;
            ST_ROUND:  n_state = ST_SQ_RE;
            ST_SQ_RE:  n_state = ST_SQ_IM;
            ST_SQ_IM:  n_state = ST_PWR;
            ST_PWR:    n_state = ST_PUSH;
            ST_PUSH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.mul_en    = 1'b0;
        o_cmd.mul_op    = MUL_P0;
        o_cmd.acc_en    = 1'b0;
        o_cmd.acc_op    = MUL_P0;
        o_cmd.upd_en    = 1'b0;
        o_cmd.round_en  = 1'b0;
        o_cmd.push      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_fire;
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = step_op(r_step);
                // products registered in the previous step are summed in this step
                o_cmd.acc_en = (r_step != 2'd0);
                o_cmd.acc_op = step_op(r_step - 2'd1);
            end
            ST_DRAIN: begin
                o_cmd.acc_en = 1'b1;
                o_cmd.acc_op = MUL_P3;
            end
            ST_UPDATE: o_cmd.upd_en   = 1'b1;
            ST_ROUND:  o_cmd.round_en = 1'b1;
            ST_SQ_RE: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_SQ_RE;
            end
            ST_SQ_IM: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_SQ_IM;
                o_cmd.acc_en = 1'b1;
                o_cmd.acc_op = MUL_SQ_RE;
            end
            ST_PWR: begin
                o_cmd.acc_en = 1'b1;
                o_cmd.acc_op = MUL_SQ_IM;
            end
            ST_PUSH:   o_cmd.push = i_sts.out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // an accepted sample always starts the product sequence at step zero
    a_fire_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_fire |=> (r_state == ST_MUL) && (r_step == 2'd0))
        else $error("accepted sample did not start the multiply sequence");

    // four product steps, then the drain
    a_mul_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) && (r_step == 2'd3) |=> (r_state == ST_DRAIN))
        else $error("multiply sequence length wrong");

    // a sample that does not end the block returns straight to idle
    a_no_result_mid_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) && !i_sts.last |=> (r_state == ST_IDLE))
        else $error("result path entered for a sample that is not last");
`endif

endmodule

[rtl/sbdp_dp.sv]
// datapath: rotation registers, phasor, accumulators, two shared multipliers, result register
module sbdp_dp #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_LOG_LEN = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // sample transfer
    input  logic signed [SAMPLE_BITS-1:0]          i_sample_re,
    input  logic signed [SAMPLE_BITS-1:0]          i_sample_im,
    input  logic                                   i_is_last,
    // register write
    input  logic                                   i_cfg_we,
    input  logic [sbdp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sbdp_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // control
    input  sbdp_pkg::t_cmd                         i_cmd,
    output sbdp_pkg::t_sts                         o_sts,
    // result transfer
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic signed [sbdp_pkg::BIN_W-1:0]      o_bin_re,
    output logic signed [sbdp_pkg::BIN_W-1:0]      o_bin_im,
    output logic        [sbdp_pkg::PWR_W-1:0]      o_bin_power
);
    import sbdp_pkg::*;

    localparam int PH_W       = 32;
    localparam int ACC_W      = 56;
    localparam int WIDE_W     = 64;
    localparam int PA_W       = SAMPLE_BITS + PH_W;
    localparam int TERM_W     = PA_W + 1;
    localparam int AF_RAW     = ACC_W - (SAMPLE_BITS + MAX_LOG_LEN + 3);
    localparam int ACC_FRAC   = (AF_RAW > 30) ? 30 : AF_RAW;
    localparam int TERM_SHIFT = 30 - ACC_FRAC;

    localparam logic signed [PH_W-1:0]   Q30_ONE  = 32'sd1073741824;
    localparam logic signed [WIDE_W-1:0] PH_HALF  = 64'sd536870912;
    localparam logic signed [WIDE_W-1:0] ACC_HALF = 64'sd1 <<< (ACC_FRAC - 1);

    // saturate a wide signed value to a signed range of the given width
    function automatic logic signed [WIDE_W-1:0] sat_s(input logic signed [WIDE_W-1:0] x,
                                                      input int unsigned bits);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi) begin
            return hi;
        end else if (x < lo) begin
            return lo;
        end
        return x;
    endfunction

    // limit a rotation part to plus or minus one
    function automatic logic signed [PH_W-1:0] clamp_one(input logic signed [PH_W-1:0] x);
        if (x > Q30_ONE) begin
            return Q30_ONE;
        end else if (x < -Q30_ONE) begin
            return -Q30_ONE;
        end
        return x;
    endfunction

    logic signed [PH_W-1:0]        r_cos, r_sin;
    logic signed [PH_W-1:0]        r_pre, r_pim;
    logic signed [ACC_W-1:0]       r_acc_re, r_acc_im;
    logic signed [SAMPLE_BITS-1:0] r_sr, r_si;
    logic                          r_last;
    logic signed [PA_W-1:0]        r_prod_a;
    logic signed [WIDE_W-1:0]      r_prod_b;
    logic signed [TERM_W-1:0]      r_term_re, r_term_im;
    logic signed [WIDE_W-1:0]      r_rot_re, r_rot_im;
    logic signed [BIN_W-1:0]       r_bre, r_bim;
    logic        [PWR_W-1:0]       r_power;
    logic                          r_out_valid;
    logic signed [BIN_W-1:0]       r_out_re, r_out_im;
    logic        [PWR_W-1:0]       r_out_power;

    logic signed [SAMPLE_BITS-1:0] w_ax;
    logic signed [PH_W-1:0]        w_ay, w_bx, w_by;
    logic signed [TERM_W-1:0]      w_tsh_re, w_tsh_im;
    logic signed [WIDE_W-1:0]      w_asum_re, w_asum_im;
    logic signed [WIDE_W-1:0]      w_prnd_re, w_prnd_im;
    logic signed [WIDE_W-1:0]      w_unit_re, w_unit_im;
    logic                          w_out_free;

    // rotation registers, clamped as they are written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos <= Q30_ONE;
            r_sin <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_ROT_COS) begin
                r_cos <= clamp_one(signed'(i_cfg_data));
            end else if (i_cfg_index == REG_ROT_SIN) begin
                r_sin <= clamp_one(signed'(i_cfg_data));
            end
        end
    end

    // sample capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sr   <= i_sample_re;
            r_si   <= i_sample_im;
            r_last <= i_is_last;
        end
    end

    // multiplier operand selection
    always_comb begin
        w_ax = r_sr;
        w_ay = r_pre;
        w_bx = r_pre;
        w_by = r_cos;
        unique case (i_cmd.mul_op)
            MUL_P0: begin
                w_ax = r_sr; w_ay = r_pre; w_bx = r_pre; w_by = r_cos;
            end
            MUL_P1: begin
                w_ax = r_si; w_ay = r_pim; w_bx = r_pim; w_by = r_sin;
            end
            MUL_P2: begin
                w_ax = r_sr; w_ay = r_pim; w_bx = r_pre; w_by = r_sin;
            end
            MUL_P3: begin
                w_ax = r_si; w_ay = r_pre; w_bx = r_pim; w_by = r_cos;
            end
            MUL_SQ_RE: begin
                w_bx = r_bre; w_by = r_bre;
            end
            MUL_SQ_IM: begin
                w_bx = r_bim; w_by = r_bim;
            end
            default: begin
                w_bx = r_pre;
            end
        endcase
    end

    // the two multipliers, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod_a <= PA_W'(w_ax) * PA_W'(w_ay);
            r_prod_b <= WIDE_W'(w_bx) * WIDE_W'(w_by);
        end
    end

    // product summing for term, rotation and power
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_en) begin
            unique case (i_cmd.acc_op)
                MUL_P0: begin
                    r_term_re <= TERM_W'(r_prod_a);
                    r_rot_re  <= r_prod_b;
                end
                MUL_P1: begin
                    r_term_re <= r_term_re - TERM_W'(r_prod_a);
                    r_rot_re  <= r_rot_re - r_prod_b;
                end
                MUL_P2: begin
                    r_term_im <= TERM_W'(r_prod_a);
                    r_rot_im  <= r_prod_b;
                end
                MUL_P3: begin
                    r_term_im <= r_term_im + TERM_W'(r_prod_a);
                    r_rot_im  <= r_rot_im + r_prod_b;
                end
                MUL_SQ_RE: r_power <= $unsigned(r_prod_b);
                MUL_SQ_IM: r_power <= r_power + $unsigned(r_prod_b);
                default: begin
                    r_power <= r_power;
                end
            endcase
        end
    end

    // accumulate and rotate arithmetic
    always_comb begin
        w_tsh_re  = r_term_re >>> TERM_SHIFT;
        w_tsh_im  = r_term_im >>> TERM_SHIFT;
        w_asum_re = WIDE_W'(r_acc_re) + WIDE_W'(w_tsh_re);
        w_asum_im = WIDE_W'(r_acc_im) + WIDE_W'(w_tsh_im);
        w_prnd_re = (r_rot_re + PH_HALF) >>> 30;
        w_prnd_im = (r_rot_im + PH_HALF) >>> 30;
        w_unit_re = (WIDE_W'(r_acc_re) + ACC_HALF) >>> ACC_FRAC;
        w_unit_im = (WIDE_W'(r_acc_im) + ACC_HALF) >>> ACC_FRAC;
    end

    // phasor and accumulator state, restarted after the last sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre    <= Q30_ONE;
            r_pim    <= '0;
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (i_cmd.upd_en) begin
            r_acc_re <= ACC_W'(sat_s(w_asum_re, ACC_W));
            r_acc_im <= ACC_W'(sat_s(w_asum_im, ACC_W));
            r_pre    <= PH_W'(sat_s(w_prnd_re, PH_W));
            r_pim    <= PH_W'(sat_s(w_prnd_im, PH_W));
        end else if (i_cmd.round_en) begin
            r_pre    <= Q30_ONE;
            r_pim    <= '0;
            r_acc_re <= '0;
            r_acc_im <= '0;
        end
    end

    // bin in sample units
    always_ff @(posedge i_clk) begin
        if (i_cmd.round_en) begin
            r_bre <= BIN_W'(sat_s(w_unit_re, BIN_W));
            r_bim <= BIN_W'(sat_s(w_unit_im, BIN_W));
        end
    end

    // output register
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_re    <= r_bre;
            r_out_im    <= r_bim;
            r_out_power <= r_power;
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.out_free = w_out_free;
    assign o_out_valid    = r_out_valid;
    assign o_bin_re       = r_out_re;
    assign o_bin_im       = r_out_im;
    assign o_bin_power    = r_out_power;

`ifndef NO_ASSERTIONS
    // a result is only loaded into a free output register
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> w_out_free)
        else $error("result loaded over an untaken result");

    // a loaded result is offered on the next cycle
    a_push_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> r_out_valid)
        else $error("loaded result not offered");

    // an offered result stays offered until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid)
        else $error("offered result withdrawn before transfer");
`endif

endmodule

[rtl/single_bin_dtft_power_unit.sv]
// top level of the single-bin dtft power unit
// Accumulates sum(x[n] * p^n) over a block of complex samples, where p is the
// rotation step written as cosine and sine in Q1.30 (register 0 and register 1,
// each clamped to plus or minus one as it is written). On the sample that
// carries is_last the unit returns the sum rounded to sample units and
// saturated to 32 bits, with its exact squared magnitude, then restarts with a
// zero sum and a phasor of one. Samples are taken one at a time: after a
// transfer, ready stays low while the two shared multipliers (one sample by
// phasor, one phasor by step) step through four products, then a summing
// step and an update step, and it returns in the idle state that takes the
// next sample. A last sample adds rounding, two squares on the phasor
// multiplier, power sum and result load before ready returns, plus any wait
// of the previous result in the output register. Register writes are taken
// on every cycle.
module single_bin_dtft_power_unit #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_LOG_LEN = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sbdp_smp_if.sink        i_smp,
    sbdp_cfg_if.sink        i_cfg,
    sbdp_bin_if.source      o_bin
);
    import sbdp_pkg::*;

    logic w_in_ready;
    logic w_in_fire;
    t_cmd w_cmd;
    t_sts w_sts;

    // handshakes
    assign i_smp.ready = w_in_ready;
    assign w_in_fire   = i_smp.valid && w_in_ready;
    assign i_cfg.ready = 1'b1;

    // sequencer
    sbdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (w_in_fire),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // arithmetic and state
    sbdp_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_LOG_LEN (MAX_LOG_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_re (i_smp.sample_re),
        .i_sample_im (i_smp.sample_im),
        .i_is_last   (i_smp.is_last),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (o_bin.ready),
        .o_out_valid (o_bin.valid),
        .o_bin_re    (o_bin.bin_re),
        .o_bin_im    (o_bin.bin_im),
        .o_bin_power (o_bin.bin_power)
    );

endmodule

[verif/tb_single_bin_dtft_power_unit.sv]
// testbench for the single-bin dtft power unit: sample blocks checked against a bit-exact predictor
module tb_single_bin_dtft_power_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sbdp_pkg::*;

    // block parameters and fixed-point formats
    localparam int SAMPLE_BITS  = 16;
    localparam int MAX_LOG_LEN  = 16;
    localparam int ACC_W        = 56;
    localparam int ACC_FRAC_RAW = ACC_W - (SAMPLE_BITS + MAX_LOG_LEN + 3);
    localparam int ACC_FRAC     = (ACC_FRAC_RAW > 30) ? 30 : ACC_FRAC_RAW;

    localparam longint Q30_ONE  = 64'sd1073741824;
    localparam longint Q30_HALF = 64'sd536870912;

    localparam logic signed [31:0] ROT_ONE       = 32'sh4000_0000;
    localparam logic signed [31:0] ROT_MINUS_ONE = 32'shC000_0000;
    localparam logic signed [31:0] ROT_COS45     = 32'sh2D41_3CCD;
    localparam logic signed [31:0] ROT_MINUS_S45 = 32'shD2BE_C333;

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int IDLE_PCT      = 38;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS  = 550;

    typedef struct {
        logic signed [BIN_W-1:0] re;
        logic signed [BIN_W-1:0] im;
        logic        [PWR_W-1:0] power;
    } t_bin_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sbdp_smp_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp_ch ();
    sbdp_cfg_if cfg_ch ();
    sbdp_bin_if bin_ch ();

    single_bin_dtft_power_unit #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_LOG_LEN (MAX_LOG_LEN)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_ch),
        .i_cfg   (cfg_ch),
        .o_bin   (bin_ch)
    );

    // predictor state
    logic signed [31:0] step_cos;
    logic signed [31:0] step_sin;
    longint             phasor_re;
    longint             phasor_im;
    longint             sum_re;
    longint             sum_im;
    t_bin_result        bin_expected[$];

    int fail_count   = 0;
    int smp_idle_pct = IDLE_PCT;
    int out_idle_pct = IDLE_PCT;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint saturate(input longint x, input int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (x > hi) return hi;
        if (x < -hi - 1) return -hi - 1;
        return x;
    endfunction

    // rotation registers act as if limited to plus or minus one
    function automatic longint clamp_unit(input logic signed [31:0] r);
        longint x;
        x = r;
        if (x > Q30_ONE) return Q30_ONE;
        if (x < -Q30_ONE) return -Q30_ONE;
        return x;
    endfunction

    function automatic longint round_to_units(input longint a);
        return saturate((a + (longint'(1) <<< (ACC_FRAC - 1))) >>> ACC_FRAC, BIN_W);
    endfunction

    function automatic void restart_block();
        phasor_re = Q30_ONE;
        phasor_im = 0;
        sum_re    = 0;
        sum_im    = 0;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        if (idx == REG_ROT_COS) step_cos = data;
        else if (idx == REG_ROT_SIN) step_sin = data;
    endfunction

    // one sample: accumulate x * phasor, rotate the phasor, close the block on last
    function automatic void accumulate_sample(input logic signed [SAMPLE_BITS-1:0] re_in,
                                              input logic signed [SAMPLE_BITS-1:0] im_in,
                                              input logic last);
        longint sr, si, c, s, tre, tim, nre, nim, bre, bim;
        t_bin_result res;
        sr = re_in;
        si = im_in;
        c  = clamp_unit(step_cos);
        s  = clamp_unit(step_sin);

        tre    = sr * phasor_re - si * phasor_im;
        tim    = sr * phasor_im + si * phasor_re;
        sum_re = saturate(sum_re + (tre >>> (30 - ACC_FRAC)), ACC_W);
        sum_im = saturate(sum_im + (tim >>> (30 - ACC_FRAC)), ACC_W);

        nre       = phasor_re * c - phasor_im * s;
        nim       = phasor_re * s + phasor_im * c;
        phasor_re = saturate((nre + Q30_HALF) >>> 30, 32);
        phasor_im = saturate((nim + Q30_HALF) >>> 30, 32);

        if (last) begin
            bre       = round_to_units(sum_re);
            bim       = round_to_units(sum_im);
            res.re    = bre[BIN_W-1:0];
            res.im    = bim[BIN_W-1:0];
            res.power = bre * bre;
            res.power = res.power + bim * bim;
            bin_expected.push_back(res);
            restart_block();
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    // caller stands at a rising edge; valid stays high until a gap is chosen
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] re_in,
                               input logic signed [SAMPLE_BITS-1:0] im_in,
                               input logic last);
        if ($urandom_range(99) < smp_idle_pct) begin
            smp_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        smp_ch.valid     <= 1'b1;
        smp_ch.sample_re <= re_in;
        smp_ch.sample_im <= im_in;
        smp_ch.is_last   <= last;
        do @(posedge i_clk); while (!smp_ch.ready);
        accumulate_sample(re_in, im_in, last);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_register(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop sending, wait for every result, then let the last sample finish
    task automatic settle_block();
        smp_ch.valid <= 1'b0;
        while (bin_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(7))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return {{(SAMPLE_BITS-3){raw[3]}}, raw[2:0]};
            default: return raw[SAMPLE_BITS-1:0];
        endcase
    endfunction

    task automatic write_random_rotation();
        real         ang;
        logic [31:0] c;
        logic [31:0] s;
        case ($urandom_range(7))
            0: begin c = ROT_ONE;       s = '0;            end
            1: begin c = ROT_MINUS_ONE; s = '0;            end
            2: begin c = '0;            s = ROT_ONE;       end
            3: begin c = '0;            s = ROT_MINUS_ONE; end
            4: begin c = $urandom;      s = $urandom;      end
            default: begin
                ang = 2.0 * 3.14159265358979323846 * ($urandom / 4294967296.0);
                c   = $rtoi($cos(ang) * 1073741824.0);
                s   = $rtoi(-$sin(ang) * 1073741824.0);
            end
        endcase
        if ($urandom_range(3) == 0)
            write_reg(($urandom_range(1) != 0) ? REG_SPARE_2 : REG_SPARE_3, $urandom);
        write_reg(REG_ROT_COS, c);
        write_reg(REG_ROT_SIN, s);
    endtask

    // ---------------------------------------------------------------- tests

    // reset step of one: the bin is the plain sum of the samples
    task automatic test_unit_step();
        send_sample(SMP_MAX, SMP_MIN, 1'b1);
        send_sample(SMP_MIN, SMP_MIN, 1'b0);
        send_sample(SMP_MIN, SMP_MIN, 1'b0);
        send_sample(SMP_MAX, SMP_MAX, 1'b1);
        send_sample('0, '0, 1'b1);
    endtask

    // eighth-turn step leaves fractions for the output rounding
    task automatic test_fractional_rotation();
        settle_block();
        write_reg(REG_ROT_COS, ROT_COS45);
        write_reg(REG_ROT_SIN, ROT_MINUS_S45);
        send_sample(16'sd1, 16'sd0, 1'b0);
        send_sample(-16'sd1, 16'sd2, 1'b0);
        send_sample(SMP_MAX, SMP_MIN, 1'b0);
        send_sample(16'sd3, -16'sd5, 1'b0);
        send_sample(-16'sd7, 16'sd1, 1'b1);
    endtask

    // out-of-range step values clamp to one and minus one, so the phasor grows and saturates
    task automatic test_register_clamp();
        settle_block();
        write_reg(REG_ROT_COS, 32'h7FFF_FFFF);
        write_reg(REG_ROT_SIN, 32'h8000_0000);
        send_sample(SMP_MAX, SMP_MAX, 1'b0);
        send_sample(SMP_MIN, SMP_MAX, 1'b0);
        send_sample(SMP_MAX, SMP_MIN, 1'b0);
        send_sample(SMP_MIN, SMP_MIN, 1'b0);
        send_sample(SMP_MAX, SMP_MAX, 1'b0);
        send_sample(SMP_MIN, SMP_MAX, 1'b1);
    endtask

    // writes to the spare indexes must leave the step alone
    task automatic test_unused_index();
        settle_block();
        write_reg(REG_ROT_COS, ROT_MINUS_ONE);
        write_reg(REG_ROT_SIN, '0);
        write_reg(REG_SPARE_2, ROT_ONE);
        write_reg(REG_SPARE_3, 32'hFFFF_FFFF);
        send_sample(SMP_MAX, 16'sd1, 1'b0);
        send_sample(SMP_MIN, -16'sd1, 1'b0);
        send_sample(SMP_MAX, 16'sd0, 1'b1);
    endtask

    // random blocks under changing steps, sometimes left open across a register change
    task automatic test_random_blocks();
        int sent;
        int phase;
        int n_blocks;
        int len;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            settle_block();
            write_random_rotation();
            if (phase == 3) begin
                smp_idle_pct = 0;
                out_idle_pct = 0;
                n_blocks     = 12;
            end else begin
                smp_idle_pct = IDLE_PCT;
                out_idle_pct = IDLE_PCT;
                n_blocks     = $urandom_range(2, 8);
            end
            for (int b = 0; b < n_blocks; b++) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                    send_sample(rand_sample(), rand_sample(), k == len - 1);
                sent += len;
            end
            if ($urandom_range(3) == 0) begin
                len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++)
                    send_sample(rand_sample(), rand_sample(), 1'b0);
                sent += len;
            end
            phase++;
        end
        smp_idle_pct = IDLE_PCT;
        out_idle_pct = IDLE_PCT;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n          <= 1'b0;
        smp_ch.valid     <= 1'b0;
        smp_ch.sample_re <= '0;
        smp_ch.sample_im <= '0;
        smp_ch.is_last   <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_ROT_COS;
        cfg_ch.data      <= '0;
        step_cos = ROT_ONE;
        step_sin = '0;
        restart_block();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_unit_step();
        test_fractional_rotation();
        test_register_clamp();
        test_unused_index();
        test_random_blocks();
        settle_block();

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // result side back-pressure
    initial begin
        bin_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            bin_ch.ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_bin_result want;
        if (i_rst_n && bin_ch.valid && bin_ch.ready) begin
            if (bin_expected.size() == 0) begin
                $error("unexpected bin result: bin_re %0d bin_im %0d", bin_ch.bin_re,
                       bin_ch.bin_im);
                fail_count++;
            end else begin
                want = bin_expected.pop_front();
                if (bin_ch.bin_re !== want.re) begin
                    $error("bin_re mismatch: expected %0d, actual %0d", want.re, bin_ch.bin_re);
                    fail_count++;
                end
                if (bin_ch.bin_im !== want.im) begin
                    $error("bin_im mismatch: expected %0d, actual %0d", want.im, bin_ch.bin_im);
                    fail_count++;
                end
                if (bin_ch.bin_power !== want.power) begin
                    $error("bin_power mismatch: expected %0d, actual %0d", want.power,
                           bin_ch.bin_power);
                    fail_count++;
                end
            end
        end
    end

    // run limit, several times the slowest correct run
    initial begin
        #(50_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule
